### hdl/fbp_pkg.sv
package fbp_pkg;

    // Default depth of the base store, in bases.
    localparam int DEF_MAX_READ_LENGTH = 256;

    // Bases per output word.
    localparam int GROUP_BITS  = 32;
    localparam int GROUP_SHIFT = $clog2(GROUP_BITS);
    localparam int PLANE_COUNT = 4;

    // Fixed field widths.
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int RL_W   = 9;
    localparam int GIDX_W = 3;
    localparam int PIDX_W = 2;
    localparam int CODE_W = 3;

    // Configuration port.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_READ_LENGTH  = 2'd0;
    localparam logic [RL_W-1:0]       READ_LENGTH_RESET = 9'd150;

    // Characters of interest.
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UC = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_UG = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_UT = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LC = 8'h63;
    localparam logic [BYTE_W-1:0] CHAR_LG = 8'h67;
    localparam logic [BYTE_W-1:0] CHAR_LT = 8'h74;

    // Stored base codes; the code of a base is also its plane index.
    localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

    localparam logic [PIDX_W-1:0] PLANE_T = 2'd3;

    function automatic logic [CODE_W-1:0] base_code(input logic [BYTE_W-1:0] b);
        logic [CODE_W-1:0] c;
        case (b)
            CHAR_UA, CHAR_LA: c = CODE_A;
            CHAR_UC, CHAR_LC: c = CODE_C;
            CHAR_UG, CHAR_LG: c = CODE_G;
            CHAR_UT, CHAR_LT: c = CODE_T;
            default:          c = CODE_OTHER;
        endcase
        return c;
    endfunction

endpackage

### hdl/fbp_if.sv
interface fbp_text_if;
    logic                      valid;
    logic                      ready;
    logic [fbp_pkg::BYTE_W-1:0] text_byte;
    logic                      end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface fbp_plane_if;
    logic                       valid;
    logic                       ready;
    logic [fbp_pkg::WORD_W-1:0] plane_word;
    logic                       is_reverse;
    logic [fbp_pkg::GIDX_W-1:0] group_index;
    logic [fbp_pkg::PIDX_W-1:0] plane_index;
    logic                       last_of_record;

    modport source (output valid, output plane_word, output is_reverse, output group_index,
                    output plane_index, output last_of_record, input ready);
    modport sink   (input valid, input plane_word, input is_reverse, input group_index,
                    input plane_index, input last_of_record, output ready);
endinterface

### hdl/fbp_store.sv
module fbp_store #(
    parameter int MAX_READ_LENGTH = fbp_pkg::DEF_MAX_READ_LENGTH
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(MAX_READ_LENGTH)-1:0]  wr_addr,
    input  logic [fbp_pkg::CODE_W-1:0]          wr_code,
    input  logic [$clog2(MAX_READ_LENGTH)-1:0]  rd_addr,
    output logic [fbp_pkg::CODE_W-1:0]          rd_code
);
    import fbp_pkg::*;

    logic [CODE_W-1:0] store_reg [MAX_READ_LENGTH];
    logic [CODE_W-1:0] rd_code_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_code;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_code_reg <= store_reg[rd_addr];
    end

    assign rd_code = rd_code_reg;

endmodule

### hdl/fbp_parse.sv
module fbp_parse #(
    parameter int MAX_READ_LENGTH = fbp_pkg::DEF_MAX_READ_LENGTH
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [fbp_pkg::RL_W-1:0]                          read_length,
    input  logic                                              accept,
    input  logic [fbp_pkg::BYTE_W-1:0]                        text_byte,
    input  logic                                              end_of_input,
    output logic                                              wr_en,
    output logic [$clog2(MAX_READ_LENGTH)-1:0]                wr_addr,
    output logic [fbp_pkg::CODE_W-1:0]                        wr_code,
    output logic                                              start,
    output logic [$clog2(MAX_READ_LENGTH+1)-1:0]              start_len,
    output logic [$clog2((MAX_READ_LENGTH+fbp_pkg::GROUP_BITS-1)
                         /fbp_pkg::GROUP_BITS+1)-1:0]         start_groups
);
    import fbp_pkg::*;

    localparam int MAX_GROUPS = (MAX_READ_LENGTH + GROUP_BITS - 1) / GROUP_BITS;
    localparam int ADDR_W     = $clog2(MAX_READ_LENGTH);
    localparam int CNT_W      = $clog2(MAX_READ_LENGTH + 1);
    localparam int GRP_W      = $clog2(MAX_GROUPS + 1);
    localparam int LIM_W      = $clog2(MAX_GROUPS * GROUP_BITS + 1);
    localparam int CMP_W      = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [RL_W-1:0] RL_MAX   = RL_W'(MAX_READ_LENGTH);
    localparam logic [RL_W-1:0] RL_ONE   = RL_W'(1);
    localparam logic [1:0]      PHASE_SEQ  = 2'd1;
    localparam logic [1:0]      PHASE_QUAL = 2'd3;

    logic [1:0]       phase_reg,  phase_next;
    logic             inside_reg, inside_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    logic [RL_W-1:0]  rl_clamped;
    logic [RL_W:0]    rl_round;
    logic [GRP_W-1:0] groups;
    logic [LIM_W-1:0] limit;
    logic             is_term;
    logic [CNT_W-1:0] cnt_eff;
    logic             store_ok;

    // Number of 32-base groups from the clamped read length.
    always_comb
    begin
        if (read_length == '0)
        begin
            rl_clamped = RL_ONE;
        end
        else if (read_length > RL_MAX)
        begin
            rl_clamped = RL_MAX;
        end
        else
        begin
            rl_clamped = read_length;
        end
        rl_round = {1'b0, rl_clamped} + (RL_W+1)'(GROUP_BITS - 1);
        groups   = GRP_W'(rl_round >> GROUP_SHIFT);
        limit    = LIM_W'({groups, {GROUP_SHIFT{1'b0}}});
    end

    assign is_term  = (text_byte == CHAR_LF) || (text_byte == CHAR_CR);
    // The first base of a sequence line restarts the count.
    assign cnt_eff  = (!is_term && !inside_reg && phase_reg == PHASE_SEQ) ? '0 : count_reg;
    assign store_ok = (phase_reg == PHASE_SEQ) && !is_term
                      && (CMP_W'(cnt_eff) < CMP_W'(limit))
                      && (cnt_eff < CNT_W'(MAX_READ_LENGTH));

    assign wr_en   = accept && store_ok;
    assign wr_addr = cnt_eff[ADDR_W-1:0];
    assign wr_code = base_code(text_byte);

    // A record closes on the end of its quality line, or on end of input inside it.
    assign start        = accept && (phase_reg == PHASE_QUAL)
                          && (is_term ? inside_reg : end_of_input);
    assign start_len    = (CMP_W'(count_reg) < CMP_W'(limit)) ? count_reg : CNT_W'(limit);
    assign start_groups = groups;

    always_comb
    begin
        phase_next  = phase_reg;
        inside_next = inside_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (is_term)
            begin
                if (inside_reg)
                begin
                    phase_next  = phase_reg + 2'd1;
                    inside_next = 1'b0;
                end
            end
            else
            begin
                inside_next = 1'b1;
                count_next  = store_ok ? (cnt_eff + CNT_W'(1)) : cnt_eff;
            end
            if (end_of_input)
            begin
                phase_next  = '0;
                inside_next = 1'b0;
                count_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            inside_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            inside_reg <= inside_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/fbp_emit.sv
module fbp_emit #(
    parameter int MAX_READ_LENGTH = fbp_pkg::DEF_MAX_READ_LENGTH
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [$clog2(MAX_READ_LENGTH+1)-1:0]              start_len,
    input  logic [$clog2((MAX_READ_LENGTH+fbp_pkg::GROUP_BITS-1)
                         /fbp_pkg::GROUP_BITS+1)-1:0]         start_groups,
    output logic [$clog2(MAX_READ_LENGTH)-1:0]                rd_addr,
    input  logic [fbp_pkg::CODE_W-1:0]                        rd_code,
    output logic                                              busy,
    fbp_plane_if.source                                       plane_ch
);
    import fbp_pkg::*;

    localparam int MAX_GROUPS = (MAX_READ_LENGTH + GROUP_BITS - 1) / GROUP_BITS;
    localparam int ADDR_W     = $clog2(MAX_READ_LENGTH);
    localparam int CNT_W      = $clog2(MAX_READ_LENGTH + 1);
    localparam int GRP_W      = $clog2(MAX_GROUPS + 1);
    localparam int GI_W       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int POS_W      = GI_W + GROUP_SHIFT;
    localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int BIT_W      = $clog2(GROUP_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FILL = 3'b010,
        ST_SEND = 3'b100
    } emit_state_t;

    emit_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [GRP_W-1:0]  groups_reg, groups_next;
    logic              rev_reg, rev_next;
    logic [GI_W-1:0]   grp_reg, grp_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [PIDX_W-1:0] plane_reg, plane_next;
    logic              vld_d_reg, vld_d_next;
    logic              out_valid_reg, out_valid_next;

    logic [WORD_W-1:0] sr_reg [PLANE_COUNT];
    logic [WORD_W-1:0] sr_next [PLANE_COUNT];
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic              out_rev_reg, out_rev_next;
    logic [GIDX_W-1:0] out_grp_reg, out_grp_next;
    logic [PIDX_W-1:0] out_plane_reg, out_plane_next;
    logic              out_last_reg, out_last_next;

    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  rev_pos;
    logic              pos_valid;
    logic              last_group;
    logic              out_load;
    logic              shift_en;

    // Bit position covered by this read, forward or mirrored.
    assign pos       = CMP_W'({grp_reg, bit_reg[GROUP_SHIFT-1:0]});
    assign rev_pos   = CMP_W'(len_reg) - CMP_W'(1) - pos;
    assign pos_valid = (pos < CMP_W'(len_reg)) && (bit_reg < BIT_W'(GROUP_BITS));
    assign rd_addr   = rev_reg ? rev_pos[ADDR_W-1:0] : pos[ADDR_W-1:0];

    assign last_group = (GRP_W'(grp_reg) + GRP_W'(1)) == groups_reg;
    assign out_load   = !out_valid_reg || plane_ch.ready;
    assign shift_en   = (state_reg == ST_FILL) && (bit_reg != '0);
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            if (shift_en)
            begin
                sr_next[k] = {vld_d_reg && (rd_code == (rev_reg ? CODE_W'(PLANE_COUNT - 1 - k)
                                                                : CODE_W'(k))),
                              sr_reg[k][WORD_W-1:1]};
            end
            else
            begin
                sr_next[k] = sr_reg[k];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        groups_next    = groups_reg;
        rev_next       = rev_reg;
        grp_next       = grp_reg;
        bit_next       = bit_reg;
        plane_next     = plane_reg;
        vld_d_next     = pos_valid;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_rev_next   = out_rev_reg;
        out_grp_next   = out_grp_reg;
        out_plane_next = out_plane_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && plane_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    len_next    = start_len;
                    groups_next = start_groups;
                    rev_next    = 1'b0;
                    grp_next    = '0;
                    bit_next    = '0;
                    state_next  = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (bit_reg == BIT_W'(GROUP_BITS))
                begin
                    plane_next = '0;
                    state_next = ST_SEND;
                end
                else
                begin
                    bit_next = bit_reg + BIT_W'(1);
                end
            end
            ST_SEND:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = sr_reg[plane_reg];
                    out_rev_next   = rev_reg;
                    out_grp_next   = GIDX_W'(grp_reg);
                    out_plane_next = plane_reg;
                    out_last_next  = rev_reg && last_group && (plane_reg == PLANE_T);
                    plane_next     = plane_reg + PIDX_W'(1);
                    if (plane_reg == PLANE_T)
                    begin
                        bit_next = '0;
                        if (!last_group)
                        begin
                            grp_next   = grp_reg + GI_W'(1);
                            state_next = ST_FILL;
                        end
                        else if (!rev_reg)
                        begin
                            rev_next   = 1'b1;
                            grp_next   = '0;
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            groups_reg    <= '0;
            rev_reg       <= 1'b0;
            grp_reg       <= '0;
            bit_reg       <= '0;
            plane_reg     <= '0;
            vld_d_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            groups_reg    <= groups_next;
            rev_reg       <= rev_next;
            grp_reg       <= grp_next;
            bit_reg       <= bit_next;
            plane_reg     <= plane_next;
            vld_d_reg     <= vld_d_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg        <= sr_next;
        out_word_reg  <= out_word_next;
        out_rev_reg   <= out_rev_next;
        out_grp_reg   <= out_grp_next;
        out_plane_reg <= out_plane_next;
        out_last_reg  <= out_last_next;
    end

    assign plane_ch.valid          = out_valid_reg;
    assign plane_ch.plane_word     = out_word_reg;
    assign plane_ch.is_reverse     = out_rev_reg;
    assign plane_ch.group_index    = out_grp_reg;
    assign plane_ch.plane_index    = out_plane_reg;
    assign plane_ch.last_of_record = out_last_reg;

    // A new record may only be started while the sequencer is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("record started while emission in progress");

    // The closing word of a record is always the reverse T plane.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_rev_reg && out_plane_reg == PLANE_T))
        else $error("last_of_record on a word other than reverse T");

    // The fill counter never runs past one group.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> bit_reg <= BIT_W'(GROUP_BITS))
        else $error("fill counter overran a group");

    // Leaving the send state after the reverse strand finishes on the final group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && state_next == ST_IDLE) |=> (out_valid_reg && out_last_reg))
        else $error("record ended without a last word");

endmodule

### hdl/fastq_base_bitplane_packer_top.sv
// FASTQ base bit-plane packer. Text enters one byte per beat on text_ch and is
// accepted at one byte per cycle while no record is being emitted. Bases of
// each record's sequence line go into an on-chip store (up to 32 times
// ceil(read_length/32) bases, at most MAX_READ_LENGTH). When the record's
// quality line closes (on CR, LF, or an end_of_input beat inside it) the block
// stops taking text and sends 8*n beats on plane_ch, n = ceil(read_length/32):
// forward strand group by group as planes A, C, G, T, then the reverse
// complement in the same order, the final beat flagged last_of_record. Each
// 32-bit word is assembled one base per cycle from the store's single read
// port, then the four plane words of the group are sent, waiting while
// plane_ch is stalled; a record holds off text input until all its words
// are loaded for sending. A finished word waits in an output register, so
// the last word of a record can still be pending while text of the next
// record is accepted. read_length sits at APB byte address 0, resets to
// 150, and should be written only while the block is idle.
module fastq_base_bitplane_packer_top #(
    parameter int MAX_READ_LENGTH = fbp_pkg::DEF_MAX_READ_LENGTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fbp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fbp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fbp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    fbp_text_if.sink                           text_ch,
    fbp_plane_if.source                        plane_ch
);
    import fbp_pkg::*;

    localparam int MAX_GROUPS = (MAX_READ_LENGTH + GROUP_BITS - 1) / GROUP_BITS;
    localparam int ADDR_W     = $clog2(MAX_READ_LENGTH);
    localparam int CNT_W      = $clog2(MAX_READ_LENGTH + 1);
    localparam int GRP_W      = $clog2(MAX_GROUPS + 1);

    logic [RL_W-1:0]   read_length_reg, read_length_next;
    logic              cfg_write;

    logic              accept;
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CODE_W-1:0] wr_code;
    logic [ADDR_W-1:0] rd_addr;
    logic [CODE_W-1:0] rd_code;
    logic              start;
    logic [CNT_W-1:0]  start_len;
    logic [GRP_W-1:0]  start_groups;

    // The register port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_READ_LENGTH);
    assign read_length_next = cfg_write ? pwdata[RL_W-1:0] : read_length_reg;
    assign prdata    = (paddr == ADDR_READ_LENGTH)
                       ? APB_DATA_W'(read_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_length_reg <= READ_LENGTH_RESET;
        end
        else
        begin
            read_length_reg <= read_length_next;
        end
    end

    // Text is taken whenever the emission sequencer is free.
    assign text_ch.ready = !busy;
    assign accept        = text_ch.valid && text_ch.ready;

    fbp_parse #(
        .MAX_READ_LENGTH (MAX_READ_LENGTH)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .read_length  (read_length_reg),
        .accept       (accept),
        .text_byte    (text_ch.text_byte),
        .end_of_input (text_ch.end_of_input),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_code      (wr_code),
        .start        (start),
        .start_len    (start_len),
        .start_groups (start_groups)
    );

    fbp_store #(
        .MAX_READ_LENGTH (MAX_READ_LENGTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_code (wr_code),
        .rd_addr (rd_addr),
        .rd_code (rd_code)
    );

    fbp_emit #(
        .MAX_READ_LENGTH (MAX_READ_LENGTH)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .start_len    (start_len),
        .start_groups (start_groups),
        .rd_addr      (rd_addr),
        .rd_code      (rd_code),
        .busy         (busy),
        .plane_ch     (plane_ch)
    );

endmodule

### tb/fastq_base_bitplane_packer_top_test.sv
module fastq_base_bitplane_packer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fbp_pkg::*;

    // Run control. The watchdog counts cycles in which neither channel moves a
    // beat. The slowest correct stretch is one word fill plus the longest sink
    // stall, so QUIET_LIMIT leaves a wide margin. A design that keeps sending
    // unexpected beats is stopped by the mismatch limit instead.
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE         = 16;
    localparam int END_CYCLES     = 200;
    localparam int PHASE_BYTES    = 20;
    localparam int MISMATCH_LIMIT = 50;
    localparam int MAX_GROUPS     = DEF_MAX_READ_LENGTH / GROUP_BITS;

    // Line numbers within a record that matter to the packer.
    localparam logic [1:0] SEQ_LINE  = 2'd1;
    localparam logic [1:0] QUAL_LINE = 2'd3;

    localparam logic [BYTE_W-1:0] UPPER_BASES [PLANE_COUNT] =
        '{CHAR_UA, CHAR_UC, CHAR_UG, CHAR_UT};
    localparam logic [BYTE_W-1:0] LOWER_BASES [PLANE_COUNT] =
        '{CHAR_LA, CHAR_LC, CHAR_LG, CHAR_LT};

    typedef struct packed {
        logic [WORD_W-1:0] plane_word;
        logic              is_reverse;
        logic [GIDX_W-1:0] group_index;
        logic [PIDX_W-1:0] plane_index;
        logic              last_of_record;
    } plane_beat_t;

    // One row of the directed script: an optional read_length write before
    // the text (-1 for none), the text itself, whether its last byte carries
    // end_of_input, and the number of plane beats the row must produce where
    // that is obvious (-1 where only the predictor decides).
    typedef struct {
        int    read_length;
        string text;
        bit    eoi_on_last;
        int    beats;
    } script_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fbp_text_if  text_ch ();
    fbp_plane_if plane_ch ();

    fastq_base_bitplane_packer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .text_ch  (text_ch),
        .plane_ch (plane_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Packer state as the testbench sees it. It advances once per accepted text
    // beat, and the words a record produces are queued in planes_due in the
    // order the block must send them.
    logic [RL_W-1:0]   rl_reg;
    logic [1:0]        line_phase;
    logic              in_line;
    int                seq_len;
    logic [CODE_W-1:0] bases [DEF_MAX_READ_LENGTH];
    plane_beat_t       planes_due [$];

    logic [BYTE_W-1:0] record_bytes [$];
    script_row_t       script [4];
    logic [RL_W-1:0]   rl_plan [8];

    int  mismatches      = 0;
    int  beats_seen      = 0;
    int  bytes_sent      = 0;
    int  records_packed  = 0;
    int  cfg_writes      = 0;
    int  quiet_cycles    = 0;
    int  sink_hold       = 0;
    bit  sink_calm       = 1'b0;
    bit  source_calm     = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $realtime, msg);
        if (mismatches == MISMATCH_LIMIT)
        begin
            $display("Stopping after %0d mismatches.", MISMATCH_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got_v,
                               input logic [WORD_W-1:0] want_v);
        if (got_v !== want_v)
        begin
            report_mismatch($sformatf("plane beat %0d: %s is %0h, expected %0h",
                                      beats_seen, name, got_v, want_v));
        end
    endtask

    // Idle gap for either side: none while calm, otherwise mostly short with
    // an occasional long one.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Groups per record. Zero counts as one and anything past the store depth
    // is clamped to it.
    function automatic int group_count();
        int rl;
        rl = int'(rl_reg);
        if (rl == 0)
        begin
            rl = 1;
        end
        if (rl > DEF_MAX_READ_LENGTH)
        begin
            rl = DEF_MAX_READ_LENGTH;
        end
        return (rl + GROUP_BITS - 1) / GROUP_BITS;
    endfunction

    // Clearing bit 5 folds lower case onto upper case for exactly the letters
    // of interest, and for no other byte.
    function automatic logic [CODE_W-1:0] nucleotide_code(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] up;
        up = b & 8'hDF;
        if (up == CHAR_UA)
        begin
            return CODE_A;
        end
        if (up == CHAR_UC)
        begin
            return CODE_C;
        end
        if (up == CHAR_UG)
        begin
            return CODE_G;
        end
        if (up == CHAR_UT)
        begin
            return CODE_T;
        end
        return CODE_OTHER;
    endfunction

    // Builds the forward and reverse complement planes of the stored sequence
    // and queues them: forward groups first, planes A, C, G, T in each, then
    // the reverse complement in the same order.
    function automatic void pack_record();
        logic [WORD_W-1:0] fwd [MAX_GROUPS][PLANE_COUNT];
        logic [WORD_W-1:0] rc  [MAX_GROUPS][PLANE_COUNT];
        int                groups, span, p, q, g, k, s, ci;
        plane_beat_t       beat;
        groups = group_count();
        span   = groups * GROUP_BITS;
        if (seq_len < span)
        begin
            span = seq_len;
        end
        for (g = 0; g < MAX_GROUPS; g++)
        begin
            for (k = 0; k < PLANE_COUNT; k++)
            begin
                fwd[g][k] = '0;
                rc[g][k]  = '0;
            end
        end
        for (p = 0; p < span; p++)
        begin
            if (bases[p] == CODE_OTHER)
            begin
                continue;
            end
            ci = int'(bases[p]);
            q  = span - 1 - p;
            fwd[p / GROUP_BITS][ci][p % GROUP_BITS] = 1'b1;
            rc[q / GROUP_BITS][PLANE_T - ci][q % GROUP_BITS] = 1'b1;
        end
        for (s = 0; s < 2; s++)
        begin
            for (g = 0; g < groups; g++)
            begin
                for (k = 0; k < PLANE_COUNT; k++)
                begin
                    beat.plane_word     = s ? rc[g][k] : fwd[g][k];
                    beat.is_reverse     = s[0];
                    beat.group_index    = GIDX_W'(g);
                    beat.plane_index    = PIDX_W'(k);
                    beat.last_of_record = (s == 1 && g == groups - 1 && k == PLANE_COUNT - 1);
                    planes_due.push_back(beat);
                end
            end
        end
        records_packed++;
    endfunction

    // Closing the quality line is what releases a record.
    function automatic void finish_line();
        if (in_line)
        begin
            if (line_phase == QUAL_LINE)
            begin
                pack_record();
            end
            line_phase = line_phase + 2'd1;
            in_line    = 1'b0;
        end
    endfunction

    function automatic void absorb_byte(input logic [BYTE_W-1:0] b, input logic eoi);
        int limit;
        if (b == CHAR_LF || b == CHAR_CR)
        begin
            finish_line();
        end
        else
        begin
            if (!in_line)
            begin
                in_line = 1'b1;
                if (line_phase == SEQ_LINE)
                begin
                    seq_len = 0;
                end
            end
            if (line_phase == SEQ_LINE)
            begin
                limit = group_count() * GROUP_BITS;
                if (seq_len < limit && seq_len < DEF_MAX_READ_LENGTH)
                begin
                    bases[seq_len] = nucleotide_code(b);
                    seq_len++;
                end
            end
        end
        // End of input closes whatever line is open (a terminator has already
        // done so) and then forgets any partial record.
        if (eoi)
        begin
            finish_line();
            line_phase = '0;
            in_line    = 1'b0;
            seq_len    = 0;
        end
    endfunction

    // Drives one text beat. The caller is always sitting on a rising edge, so
    // valid gets at most one assignment per time step.
    task automatic push_text(input logic [BYTE_W-1:0] b, input logic eoi);
        int gap;
        if ($urandom_range(0, 63) == 0)
        begin
            source_calm = !source_calm;
        end
        gap = pick_gap(source_calm);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= b;
        text_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!text_ch.ready)
        begin
            @(posedge clk);
        end
        absorb_byte(b, eoi);
        bytes_sent++;
    endtask

    // Holds the text side until every queued plane beat has arrived. At least
    // one edge passes, so a following push_text never touches valid twice in
    // the same step.
    task automatic wait_for_planes();
        text_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (planes_due.size() != 0);
    endtask

    // Writes read_length while the block is quiet, then reads it back.
    task automatic write_read_length(input logic [RL_W-1:0] value);
        wait_for_planes();
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_READ_LENGTH;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rl_reg = value;
        cfg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata[RL_W-1:0] !== value)
        begin
            report_mismatch($sformatf("read_length reads back %0d, written %0d",
                                      prdata[RL_W-1:0], value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_base();
        int               r;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 15);
        if (r < 8)
        begin
            return UPPER_BASES[r % PLANE_COUNT];
        end
        if (r < 12)
        begin
            return LOWER_BASES[r % PLANE_COUNT];
        end
        if (r < 14)
        begin
            return "N";
        end
        // Any byte that is not a line terminator takes a position too.
        do
        begin
            b = BYTE_W'($urandom_range(0, 255));
        end
        while (b == CHAR_LF || b == CHAR_CR);
        return b;
    endfunction

    function automatic void add_printable(input int count);
        repeat (count) record_bytes.push_back(BYTE_W'($urandom_range(33, 126)));
    endfunction

    // Line end as LF or CR LF, now and then followed by an empty line.
    function automatic void add_line_end();
        if ($urandom_range(0, 3) == 0)
        begin
            record_bytes.push_back(CHAR_CR);
        end
        record_bytes.push_back(CHAR_LF);
        if ($urandom_range(0, 15) == 0)
        begin
            record_bytes.push_back($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
        end
    endfunction

    // One FASTQ record with random content. Most are well formed; some end on
    // end_of_input inside or after the quality line, some are cut short by an
    // end_of_input anywhere, and a few change read_length between the sequence
    // line and the quality line.
    task automatic feed_record(input bit force_long);
        int  limit, seq_n, split, eoi_at, last, ending, i;
        bit  retune;
        limit  = group_count() * GROUP_BITS;
        eoi_at = -1;
        record_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            record_bytes.push_back(CHAR_LF);
        end
        record_bytes.push_back("@");
        add_printable($urandom_range(0, 6));
        add_line_end();
        if (force_long)
        begin
            seq_n = $urandom_range(limit + 1, limit + 6);
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            seq_n = $urandom_range(limit - 2, limit + 6);
        end
        else
        begin
            seq_n = $urandom_range(1, 24);
        end
        repeat (seq_n) record_bytes.push_back(pick_base());
        add_line_end();
        split = record_bytes.size();
        record_bytes.push_back("+");
        add_printable($urandom_range(0, 2));
        add_line_end();
        add_printable($urandom_range(1, 16));
        ending = $urandom_range(0, 19);
        if (ending < 14)
        begin
            add_line_end();
        end
        else if (ending < 17)
        begin
            eoi_at = record_bytes.size() - 1;
        end
        else
        begin
            record_bytes.push_back(CHAR_LF);
            eoi_at = record_bytes.size() - 1;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            eoi_at = $urandom_range(0, record_bytes.size() - 1);
        end
        retune = (eoi_at < 0 || eoi_at >= split) && $urandom_range(0, 11) == 0;
        last   = (eoi_at >= 0) ? eoi_at : record_bytes.size() - 1;
        for (i = 0; i <= last; i++)
        begin
            if (retune && i == split)
            begin
                write_read_length(RL_W'($urandom_range(0, 511)));
            end
            push_text(record_bytes[i], i == eoi_at);
        end
    endtask

    // Receiving side: checks every accepted plane beat against the oldest
    // queued expectation, and drives ready with random stalls. Calm stretches
    // with ready held high come and go.
    initial
    begin
        plane_beat_t got, want;
        plane_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (plane_ch.valid && plane_ch.ready)
            begin
                got.plane_word     = plane_ch.plane_word;
                got.is_reverse     = plane_ch.is_reverse;
                got.group_index    = plane_ch.group_index;
                got.plane_index    = plane_ch.plane_index;
                got.last_of_record = plane_ch.last_of_record;
                if (planes_due.size() == 0)
                begin
                    report_mismatch($sformatf("plane beat %0d arrived with nothing expected",
                                              beats_seen));
                end
                else
                begin
                    want = planes_due.pop_front();
                    check_field("plane_word", got.plane_word, want.plane_word);
                    check_field("is_reverse", WORD_W'(got.is_reverse),
                                WORD_W'(want.is_reverse));
                    check_field("group_index", WORD_W'(got.group_index),
                                WORD_W'(want.group_index));
                    check_field("plane_index", WORD_W'(got.plane_index),
                                WORD_W'(want.plane_index));
                    check_field("last_of_record", WORD_W'(got.last_of_record),
                                WORD_W'(want.last_of_record));
                end
                beats_seen++;
            end
            if ($urandom_range(0, 255) == 0)
            begin
                sink_calm = !sink_calm;
            end
            if (!rst_n)
            begin
                plane_ch.ready <= 1'b0;
            end
            else if (sink_hold > 0)
            begin
                sink_hold--;
                plane_ch.ready <= 1'b0;
            end
            else
            begin
                plane_ch.ready <= 1'b1;
                sink_hold = pick_gap(sink_calm);
            end
        end
    end

    // Watchdog: the run is stuck if no beat moves on either channel for too
    // long. Configuration writes and settling pauses are far shorter.
    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (plane_ch.valid && plane_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d plane beats outstanding",
                         QUIET_LIMIT, planes_due.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int i, start;
        bit first;
        logic [BYTE_W-1:0] ch;

        text_ch.valid        = 1'b0;
        text_ch.text_byte    = '0;
        text_ch.end_of_input = 1'b0;

        rl_reg     = READ_LENGTH_RESET;
        line_phase = '0;
        in_line    = 1'b0;
        seq_len    = 0;

        // In the script text a tilde stands for the byte 0x00, which a string
        // cannot hold.
        script = '{
            // After reset read_length is 150: five groups, 40 beats. Lower case
            // counts as a base and N takes a position without setting a bit.
            '{-1,  "@\nacgN\n+\nI\n", 1'b0, 40},
            // Shortest read length while the sequence line is stored...
            '{1,   "@\nTa\n+\n",      1'b0, 0},
            // ...then an out-of-range value that clamps to the full store, and
            // end of input on a 0xFF byte that opens and closes the quality
            // line: eight groups, 64 beats.
            '{511, "\377",            1'b1, 64},
            // Zero read length, empty lines, and end of input on a line feed
            // that leaves a partial record, which is dropped.
            '{0,   "\015\n@\n~\n",    1'b1, 0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Each row drains fully before the next one, so the
        // beats it produced can be counted on their own.
        foreach (script[row])
        begin
            if (script[row].read_length >= 0)
            begin
                write_read_length(RL_W'(script[row].read_length));
            end
            start = beats_seen;
            for (i = 0; i < script[row].text.len(); i++)
            begin
                ch = script[row].text[i];
                if (ch == "~")
                begin
                    ch = 8'h00;
                end
                push_text(ch, script[row].eoi_on_last && i == script[row].text.len() - 1);
            end
            wait_for_planes();
            if (script[row].beats >= 0 && beats_seen - start != script[row].beats)
            begin
                report_mismatch($sformatf("script row %0d gave %0d plane beats, expected %0d",
                                          row, beats_seen - start, script[row].beats));
            end
        end

        // Random part, one read_length setting per phase: both ends of the
        // legal range, zero, the largest 9-bit value, values straddling a
        // group boundary, an out-of-range 300, and one random legal value. At
        // the shortest length the first record overruns its one-group limit.
        rl_plan = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd33, 9'd64, 9'd300, 9'd150};
        rl_plan[7] = RL_W'($urandom_range(1, 256));
        foreach (rl_plan[ph])
        begin
            write_read_length(rl_plan[ph]);
            start = bytes_sent;
            first = 1'b1;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                // A short burst of arbitrary bytes ends on end_of_input, which
                // puts the line count back at the start of a record.
                if ($urandom_range(0, 15) == 0)
                begin
                    i = $urandom_range(1, 8);
                    while (i > 0)
                    begin
                        push_text(BYTE_W'($urandom_range(0, 255)), i == 1);
                        i--;
                    end
                end
                feed_record(first && rl_plan[ph] == 9'd1);
                first = 1'b0;
            end
        end

        wait_for_planes();
        repeat (END_CYCLES) @(posedge clk);

        $display("Sent %0d text bytes; %0d records packed into %0d plane beats.",
                 bytes_sent, records_packed, beats_seen);
        $display("read_length was written %0d times, covering 0, 1, 256 and 511.",
                 cfg_writes);
        if (mismatches == 0 && planes_due.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/fbp_pkg.sv
hdl/fbp_if.sv
hdl/fbp_store.sv
hdl/fbp_parse.sv
hdl/fbp_emit.sv
hdl/fastq_base_bitplane_packer_top.sv
tb/fastq_base_bitplane_packer_top_test.sv
